### design/smsel_pkg.sv
// Shared types and constants of the set median selector.
package smsel_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MEDIAN_W  = SAMPLE_W + 1;
  localparam int COUNT_W   = 7;
  localparam int DEPTH_DEF = 64;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       last;
  } req_t;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic [COUNT_W-1:0]         sample_count;
    logic                       overflow;
  } res_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

### design/smsel_cell.sv
// One compare-and-shift cell of the sorted sample chain.
module smsel_cell
  import smsel_pkg::*;
(
  input  logic                       clk_i,
  input  cell_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       occ_i,
  input  logic                       left_occ_i,
  input  logic                       left_gt_i,
  input  logic signed [SAMPLE_W-1:0] left_value_i,
  input  logic signed [SAMPLE_W-1:0] right_value_i,
  output logic signed [SAMPLE_W-1:0] value_o,
  output logic                       gt_o
);

  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic                       take;

  assign gt_o = occ_i && (value_q > sample_i);
  assign take = gt_o || (!occ_i && left_occ_i);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = right_value_i;
    end else if (ctrl_i.insert && take) begin
      value_d = left_gt_i ? left_value_i : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

### design/set_median_selector.sv
// Top level of the set median selector: sorted cell chain, control and result register.
// A request without last is taken while idle, and the next can follow at once.
// A request with last (after any insert it carries) shifts the chain by (n-1)/2 places
// rounded down, none for an empty set, n being the kept count, then loads the result
// register once it is free; no new request is taken until then.
// Reset clears the count, the overflow flag, the control state and the result valid.
module set_median_selector
  import smsel_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  logic req_valid_i,
  output logic req_ready_o,
  output res_t res_o,
  output logic res_valid_o,
  input  logic res_ready_i
);

  localparam int CW        = $clog2(DEPTH + 1);
  localparam int SecondIdx = (DEPTH > 1) ? 1 : 0;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       shifts_q, shifts_d;
  logic                drop_q, drop_d;
  res_t                res_q, res_d;
  logic                res_valid_q, res_valid_d;

  logic                accept, full, do_insert, do_shift, out_free;
  cell_ctrl_t          ctrl;
  logic signed [SAMPLE_W-1:0] vals [DEPTH];
  logic                gts [DEPTH];
  logic signed [MEDIAN_W-1:0] v0x, v1x, median;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign full        = (count_q == CW'(DEPTH));
  assign do_insert   = accept && req_i.sample_valid && !full;
  assign do_shift    = (state_q == ST_DRAIN) && (shifts_q != '0);
  assign out_free    = !res_valid_q || res_ready_i;

  assign ctrl.insert = do_insert;
  assign ctrl.shift  = do_shift;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       occ, left_occ, left_gt;
    logic signed [SAMPLE_W-1:0] left_value, right_value;

    assign occ = (CW'(i) < count_q);
    if (i == 0) begin : g_first
      assign left_occ   = 1'b1;
      assign left_gt    = 1'b0;
      assign left_value = req_i.sample;
    end else begin : g_rest
      assign left_occ   = (CW'(i - 1) < count_q);
      assign left_gt    = gts[i-1];
      assign left_value = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_value = vals[i];
    end else begin : g_inner
      assign right_value = vals[i+1];
    end

    smsel_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .sample_i      (req_i.sample),
      .occ_i         (occ),
      .left_occ_i    (left_occ),
      .left_gt_i     (left_gt),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .value_o       (vals[i]),
      .gt_o          (gts[i])
    );
  end

  assign v0x = {vals[0][SAMPLE_W-1], vals[0]};
  assign v1x = {vals[SecondIdx][SAMPLE_W-1], vals[SecondIdx]};

  always_comb begin
    if (count_q == '0) begin
      median = '0;
    end else if (count_q[0]) begin
      median = {vals[0], 1'b0};
    end else begin
      median = v0x + v1x;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    shifts_d    = shifts_q;
    drop_d      = drop_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (do_insert) begin
            count_d = count_q + 1'b1;
          end else if (req_i.sample_valid) begin
            drop_d = 1'b1;
          end
          if (req_i.last) begin
            state_d  = ST_DRAIN;
            shifts_d = (count_d == '0) ? '0 : ((count_d - 1'b1) >> 1);
          end
        end
      end
      ST_DRAIN: begin
        if (do_shift) begin
          shifts_d = shifts_q - 1'b1;
        end else if (out_free) begin
          res_d.median_doubled = median;
          res_d.sample_count   = COUNT_W'(count_q);
          res_d.overflow       = drop_q;
          res_valid_d          = 1'b1;
          count_d              = '0;
          drop_d               = 1'b0;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      shifts_q    <= '0;
      drop_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      shifts_q    <= shifts_d;
      drop_q      <= drop_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("sample count exceeds store depth");

  a_close_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.last) |=> !req_ready_o)
    else $error("request accepted while a set is being closed");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.sample_valid && !req_i.last && !drop_q) |=>
      (drop_q == $past(full)))
    else $error("overflow flag does not match store fullness");

  a_shift_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_shift |=> (shifts_q == $past(shifts_q) - 1'b1) && (state_q == ST_DRAIN))
    else $error("drain counter did not step down");

  a_no_insert_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_shift && do_insert))
    else $error("insert and shift in the same cycle");
`endif

endmodule

### sim/set_median_selector_tb.sv
// Self-checking testbench that sorts each request set on the side and checks every median.
`timescale 1ns / 100ps

module set_median_selector_tb;
  import smsel_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = DEPTH_DEF / 2 + 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  req_t req_i       = '0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  res_t res_o;
  logic res_valid_o;
  logic res_ready_i = 1'b0;

  req_t pending_reqs[$];
  res_t expected_medians[$];
  logic signed [SAMPLE_W-1:0] kept_sorted[$];
  logic sample_dropped = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int queued_items  = 0;
  int error_count   = 0;
  int stuck_cycles  = 0;

  set_median_selector DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .res_o      (res_o),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic void sort_into_set(req_t r);
    logic signed [SAMPLE_W-1:0] s;
    logic signed [MEDIAN_W-1:0] lo, hi, med;
    res_t exp_res;
    int pos, n;
    s = r.sample;
    if (r.sample_valid) begin
      if (kept_sorted.size() >= DEPTH_DEF) begin
        sample_dropped = 1'b1;
      end else begin
        pos = kept_sorted.size();
        while (pos > 0 && kept_sorted[pos-1] > s) pos--;
        kept_sorted.insert(pos, s);
      end
    end
    if (r.last) begin
      n = kept_sorted.size();
      if (n == 0) begin
        med = '0;
      end else begin
        hi = kept_sorted[n/2];
        lo = (n % 2 == 1) ? hi : kept_sorted[n/2-1];
        med = lo + hi;
      end
      exp_res.median_doubled = med;
      exp_res.sample_count   = COUNT_W'(n);
      exp_res.overflow       = sample_dropped;
      expected_medians = {expected_medians, exp_res};
      kept_sorted.delete();
      sample_dropped = 1'b0;
    end
  endfunction

  function automatic void check_median(res_t got);
    res_t exp_res;
    if (expected_medians.size() == 0) begin
      $error("unexpected result: median_doubled %0d, sample_count %0d, overflow %0b",
             $signed(got.median_doubled), got.sample_count, got.overflow);
      error_count++;
      return;
    end
    exp_res = expected_medians.pop_front();
    if (got.median_doubled !== exp_res.median_doubled) begin
      $error("median_doubled: expected %0d, got %0d",
             $signed(exp_res.median_doubled), $signed(got.median_doubled));
      error_count++;
    end
    if (got.sample_count !== exp_res.sample_count) begin
      $error("sample_count: expected %0d, got %0d", exp_res.sample_count, got.sample_count);
      error_count++;
    end
    if (got.overflow !== exp_res.overflow) begin
      $error("overflow: expected %0b, got %0b", exp_res.overflow, got.overflow);
      error_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
    end else begin
      if (req_valid_i && req_ready_o) sort_into_set(req_i);
      if (!req_valid_i || req_ready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_i       <= pending_reqs.pop_front();
          req_valid_i <= 1'b1;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready_i <= 1'b0;
    end else begin
      res_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) check_median(res_o);
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (res_valid_o && res_ready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("set_median_selector_tb NOT OK");
      $finish;
    end
  end

  function automatic void add_req(logic signed [SAMPLE_W-1:0] s, logic v, logic l);
    req_t r;
    r.sample       = s;
    r.sample_valid = v;
    r.last         = l;
    pending_reqs = {pending_reqs, r};
    if (v || l) queued_items++;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3, 4: return SAMPLE_W'($signed($urandom_range(15)) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 0;
    if (r < 90) return $urandom_range(12, 1);
    if (r < 96) return $urandom_range(40, 13);
    return $urandom_range(DEPTH_DEF + 6, DEPTH_DEF - 4);
  endfunction

  task automatic queue_random_sets(int target);
    int start, n;
    bit last_on_sample;
    start = queued_items;
    while (queued_items - start < target) begin
      n = pick_set_size();
      last_on_sample = (n > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) add_req(SAMPLE_W'($urandom), 1'b0, 1'b0);
        add_req(pick_sample(), 1'b1, last_on_sample && (i == n - 1));
      end
      if (!last_on_sample) add_req(SAMPLE_W'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic wait_until_drained();
    while (pending_reqs.size() != 0 || req_valid_i || expected_medians.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    send_idle_pct = 12;
    recv_idle_pct = 65;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_req(16'sh1234, 1'b0, 1'b1);
    add_req(16'sh7FFF, 1'b1, 1'b1);
    add_req(16'sh8000, 1'b1, 1'b1);
    add_req(16'sh8000, 1'b1, 1'b0);
    add_req(16'sh7FFF, 1'b1, 1'b0);
    add_req(16'shFFFF, 1'b0, 1'b1);
    add_req(16'sh5A5A, 1'b0, 1'b0);
    add_req(16'sh0005, 1'b1, 1'b0);
    add_req(16'sh0005, 1'b1, 1'b0);
    add_req(-16'sd3, 1'b1, 1'b1);
    add_req(16'sd100, 1'b1, 1'b0);
    add_req(16'sd50, 1'b1, 1'b0);
    add_req(-16'sd7, 1'b1, 1'b0);
    add_req(16'sh0000, 1'b1, 1'b1);
    add_req(16'sh8000, 1'b1, 1'b0);
    add_req(16'sh8000, 1'b1, 1'b0);
    add_req(16'sh8000, 1'b1, 1'b1);
    add_req(16'sh7FFF, 1'b1, 1'b0);
    add_req(16'sh7FFF, 1'b1, 1'b0);
    add_req(16'sh0000, 1'b0, 1'b1);
    queue_random_sets(600);
    wait_until_drained();

    send_idle_pct = 65;
    recv_idle_pct = 12;
    queue_random_sets(600);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_sets(600);
    wait_until_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("set_median_selector_tb OK");
    end else begin
      $display("set_median_selector_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
design/smsel_pkg.sv
design/smsel_cell.sv
design/set_median_selector.sv
sim/set_median_selector_tb.sv
